>>> rtl/core/cmdfr_pkg.sv
// shared types and constants for the clock message deframer
`timescale 1ns / 1ps

package cmdfr_pkg;

  // depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // header bytes
  localparam logic [7:0] HDR_SYNC     = 8'h10;
  localparam logic [7:0] HDR_TIMES_B1 = 8'h18;
  localparam logic [7:0] HDR_TIMES_B2 = 8'h04;
  localparam logic [7:0] HDR_BTN_B1   = 8'h0A;
  localparam logic [7:0] HDR_BTN_B2   = 8'h05;
  localparam logic [7:0] HDR_ACK_B1   = 8'h08;
  localparam logic [7:0] HDR_ACK_B2   = 8'h01;

  // payload lengths
  localparam logic [4:0] LEN_TIMES   = 5'd20;
  localparam logic [4:0] LEN_BUTTONS = 5'd8;
  localparam logic [4:0] LEN_ACK     = 5'd4;

  // bit of the lever in the button payload
  localparam int unsigned LEVER_BIT = 6;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_BUTTONS = 2'd2,
    KIND_TIMES   = 2'd3
  } msg_kind_e;

  typedef enum logic {
    EV_BUTTON = 1'b0,
    EV_TIMES  = 1'b1
  } event_kind_e;

  typedef enum logic [2:0] {
    BTN_BACK  = 3'd0,
    BTN_PLUS  = 3'd1,
    BTN_PLAY  = 3'd2,
    BTN_MINUS = 3'd3,
    BTN_NEXT  = 3'd4,
    BTN_LEVER = 3'd5
  } button_code_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       lone_transfer;
  } in_beat_t;

  typedef struct packed {
    logic       event_kind;
    logic [2:0] button_code;
    logic [3:0] left_hours;
    logic [7:0] left_minutes;
    logic [7:0] left_seconds;
    logic [3:0] right_hours;
    logic [7:0] right_minutes;
    logic [7:0] right_seconds;
    logic       lever_state;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [3:0] left_hours;
    logic [7:0] left_minutes;
    logic [7:0] left_seconds;
    logic [3:0] right_hours;
    logic [7:0] right_minutes;
    logic [7:0] right_seconds;
    logic       lever_state;
  } times_t;

  // one decoded message handed from front to back
  typedef struct packed {
    logic       is_times;
    logic [5:0] events;   // pending button events, bit i is button code i
    times_t     times;
  } cmd_t;

endpackage

>>> rtl/core/cmdfr_front.sv
// front end: header search, payload capture and message decode
`timescale 1ns / 1ps

module cmdfr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cmdfr_pkg::in_beat_t in_data_i,
  input  logic                q_full_i,
  output logic                push_o,
  output cmdfr_pkg::cmd_t     push_data_o
);

  logic                 board_inverted_q;
  logic [7:0]           win1_q, win2_q, win1_d, win2_d;
  logic [4:0]           expected_q, expected_d;
  logic [4:0]           received_q, received_d;
  cmdfr_pkg::msg_kind_e kind_q, kind_d;
  logic                 first_pending_q, first_pending_d;
  logic                 latched_lever_q, latched_lever_d;
  logic [7:0]           pb0_q, pb1_q, pb2_q, pb3_q, pb7_q, pb8_q, pb9_q;
  logic                 lever15_q;

  logic                 accept;
  logic [4:0]           received_inc;
  logic                 msg_done;
  logic [5:0]           btn_events;
  logic                 eff_lever;
  logic                 swap;

  assign in_ready_o   = !q_full_i;
  assign accept       = in_valid_i && in_ready_o && !in_data_i.lone_transfer;
  assign received_inc = received_q + 5'd1;
  assign msg_done     = (expected_q != 5'd0) && (received_inc == expected_q);

  // rising keys and lever change
  assign btn_events = {pb0_q[cmdfr_pkg::LEVER_BIT] ^ pb1_q[cmdfr_pkg::LEVER_BIT],
                       pb0_q[4:0] & ~pb1_q[4:0]};

  // side swap decision, first report latches its own lever bit
  assign eff_lever = first_pending_q ? lever15_q : latched_lever_q;
  assign swap      = eff_lever ^ board_inverted_q;

  // command toward the back end
  always_comb begin
    push_data_o.is_times = (kind_q == cmdfr_pkg::KIND_TIMES);
    push_data_o.events   = btn_events;
    push_data_o.times.lever_state = lever15_q;
    if (swap) begin
      push_data_o.times.left_hours    = pb7_q[3:0];
      push_data_o.times.left_minutes  = pb8_q;
      push_data_o.times.left_seconds  = pb9_q;
      push_data_o.times.right_hours   = pb1_q[3:0];
      push_data_o.times.right_minutes = pb2_q;
      push_data_o.times.right_seconds = pb3_q;
    end else begin
      push_data_o.times.left_hours    = pb1_q[3:0];
      push_data_o.times.left_minutes  = pb2_q;
      push_data_o.times.left_seconds  = pb3_q;
      push_data_o.times.right_hours   = pb7_q[3:0];
      push_data_o.times.right_minutes = pb8_q;
      push_data_o.times.right_seconds = pb9_q;
    end
    push_o = accept && msg_done &&
             ((kind_q == cmdfr_pkg::KIND_TIMES) ||
              ((kind_q == cmdfr_pkg::KIND_BUTTONS) && (btn_events != 6'd0)));
  end

  // header search and payload count
  always_comb begin
    win1_d          = win1_q;
    win2_d          = win2_q;
    expected_d      = expected_q;
    received_d      = received_q;
    kind_d          = kind_q;
    first_pending_d = first_pending_q;
    latched_lever_d = latched_lever_q;
    if (accept) begin
      if (expected_q == 5'd0) begin
        win1_d = win2_q;
        win2_d = in_data_i.rx_byte;
        if (win1_q == cmdfr_pkg::HDR_SYNC) begin
          if (win2_q == cmdfr_pkg::HDR_TIMES_B1 &&
              in_data_i.rx_byte == cmdfr_pkg::HDR_TIMES_B2) begin
            kind_d     = cmdfr_pkg::KIND_TIMES;
            expected_d = cmdfr_pkg::LEN_TIMES;
            received_d = 5'd0;
          end else if (win2_q == cmdfr_pkg::HDR_BTN_B1 &&
                       in_data_i.rx_byte == cmdfr_pkg::HDR_BTN_B2) begin
            kind_d     = cmdfr_pkg::KIND_BUTTONS;
            expected_d = cmdfr_pkg::LEN_BUTTONS;
            received_d = 5'd0;
          end else if (win2_q == cmdfr_pkg::HDR_ACK_B1 &&
                       in_data_i.rx_byte == cmdfr_pkg::HDR_ACK_B2) begin
            kind_d     = cmdfr_pkg::KIND_ACK;
            expected_d = cmdfr_pkg::LEN_ACK;
            received_d = 5'd0;
          end
        end
      end else if (msg_done) begin
        received_d = 5'd0;
        expected_d = 5'd0;
        kind_d     = cmdfr_pkg::KIND_NONE;
        win1_d     = 8'd0;
        win2_d     = 8'd0;
        if (kind_q == cmdfr_pkg::KIND_TIMES && first_pending_q) begin
          first_pending_d = 1'b0;
          latched_lever_d = lever15_q;
        end
      end else begin
        received_d = received_inc;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_inverted_q <= 1'b0;
      win1_q           <= 8'd0;
      win2_q           <= 8'd0;
      expected_q       <= 5'd0;
      received_q       <= 5'd0;
      kind_q           <= cmdfr_pkg::KIND_NONE;
      first_pending_q  <= 1'b1;
      latched_lever_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        board_inverted_q <= cfg_data_i;
      end
      win1_q          <= win1_d;
      win2_q          <= win2_d;
      expected_q      <= expected_d;
      received_q      <= received_d;
      kind_q          <= kind_d;
      first_pending_q <= first_pending_d;
      latched_lever_q <= latched_lever_d;
    end
  end

  // payload bytes that the decoders read
  always_ff @(posedge clk_i) begin
    if (accept && expected_q != 5'd0) begin
      case (received_q)
        5'd0:    pb0_q     <= in_data_i.rx_byte;
        5'd1:    pb1_q     <= in_data_i.rx_byte;
        5'd2:    pb2_q     <= in_data_i.rx_byte;
        5'd3:    pb3_q     <= in_data_i.rx_byte;
        5'd7:    pb7_q     <= in_data_i.rx_byte;
        5'd8:    pb8_q     <= in_data_i.rx_byte;
        5'd9:    pb9_q     <= in_data_i.rx_byte;
        5'd15:   lever15_q <= in_data_i.rx_byte[0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/cmdfr_queue.sv
// short command queue between front and back end
`timescale 1ns / 1ps

module cmdfr_queue #(
  parameter int unsigned Depth = cmdfr_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cmdfr_pkg::cmd_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cmdfr_pkg::cmd_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmdfr_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // no overflow, no underflow
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("command pushed into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("command popped from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not follow push");

endmodule

>>> rtl/core/cmdfr_back.sv
// back end: expands commands into result beats
`timescale 1ns / 1ps

module cmdfr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  cmdfr_pkg::cmd_t      q_data_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cmdfr_pkg::out_beat_t out_data_o
);

  logic                 cur_valid_q;
  cmdfr_pkg::cmd_t      cur_q;
  logic                 out_valid_q;
  cmdfr_pkg::out_beat_t out_q, beat;

  logic                 out_free;
  logic                 emit;
  logic [5:0]           lowest;
  logic [5:0]           rest;
  logic                 cur_done;
  cmdfr_pkg::button_code_e code;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = cur_valid_q && out_free;
  assign lowest   = cur_q.events & (~cur_q.events + 6'd1);
  assign rest     = cur_q.events & (cur_q.events - 6'd1);
  assign cur_done = emit && (cur_q.is_times || rest == 6'd0);
  assign pop_o    = q_valid_i && (!cur_valid_q || cur_done);

  // first pending event in fixed key order
  always_comb begin
    case (lowest)
      6'b000001: code = cmdfr_pkg::BTN_BACK;
      6'b000010: code = cmdfr_pkg::BTN_PLUS;
      6'b000100: code = cmdfr_pkg::BTN_PLAY;
      6'b001000: code = cmdfr_pkg::BTN_MINUS;
      6'b010000: code = cmdfr_pkg::BTN_NEXT;
      6'b100000: code = cmdfr_pkg::BTN_LEVER;
      default:   code = cmdfr_pkg::BTN_BACK;
    endcase
  end

  // result beat
  always_comb begin
    beat = '0;
    if (cur_q.is_times) begin
      beat.event_kind    = cmdfr_pkg::EV_TIMES;
      beat.button_code   = cmdfr_pkg::BTN_BACK;
      beat.left_hours    = cur_q.times.left_hours;
      beat.left_minutes  = cur_q.times.left_minutes;
      beat.left_seconds  = cur_q.times.left_seconds;
      beat.right_hours   = cur_q.times.right_hours;
      beat.right_minutes = cur_q.times.right_minutes;
      beat.right_seconds = cur_q.times.right_seconds;
      beat.lever_state   = cur_q.times.lever_state;
      beat.last          = 1'b1;
    end else begin
      beat.event_kind  = cmdfr_pkg::EV_BUTTON;
      beat.button_code = code;
      beat.last        = (rest == 6'd0);
    end
  end

  // current command and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
      end else if (cur_done) begin
        cur_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end else if (emit) begin
      cur_q.events <= rest;
    end
    if (emit) begin
      out_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a button command always has an event to give
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cur_valid_q && !cur_q.is_times) |-> cur_q.events != 6'd0)
    else $error("button command without events");
  // a times report is always the last beat of its command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_q.event_kind == cmdfr_pkg::EV_TIMES) |-> out_q.last)
    else $error("times report not marked last");
  // output register is reloaded only when free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !out_ready_i) |=> $stable(out_q))
    else $error("held beat overwritten");

endmodule

>>> rtl/core/clock_message_deframer.sv
// top level of the clock message deframer
// path: a completed message passes the queue, current command and output registers
// throughput: one byte per cycle in unless the queue is full; one result beat per
//   cycle out while ready; up to six beats per button message, absorbed by the queue
// the front stalls only when the command queue is full
// reset: async active low, clears header search, counters and queue; lever latch set
`timescale 1ns / 1ps

module clock_message_deframer #(
  parameter int unsigned QueueDepth = cmdfr_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cmdfr_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cmdfr_pkg::out_beat_t out_data_o
);

  logic            push, full, pop, q_valid;
  cmdfr_pkg::cmd_t push_data, q_data;

  // header search and decode
  cmdfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decoupling queue
  cmdfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  // result beat generation
  cmdfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
